### sv/arbb_pkg.sv
`timescale 1ns / 1ps

package arbb_pkg;

    localparam int Q_WIDTH     = 32;
    localparam int Q_FRAC_BITS = 16;
    localparam int SPAN_WIDTH  = 31;
    localparam int PROD_WIDTH  = 2 * Q_WIDTH;
    // wide enough for a product shifted down, or a sum of two Q16.16 values
    localparam int WIDE_WIDTH  = PROD_WIDTH - Q_FRAC_BITS + 1;
    localparam int CFG_IDX_W   = 3;

    typedef logic signed [Q_WIDTH-1:0]    t_q;
    typedef logic signed [PROD_WIDTH-1:0] t_prod;
    typedef logic signed [WIDE_WIDTH-1:0] t_wide;
    typedef logic [SPAN_WIDTH-1:0]        t_span;

    localparam t_q Q_MAX   = {1'b0, {(Q_WIDTH-1){1'b1}}};
    localparam t_q Q_MIN   = {1'b1, {(Q_WIDTH-1){1'b0}}};
    localparam t_q Q_ONE   = t_q'(1) <<< Q_FRAC_BITS;
    localparam t_q Q_ZERO  = '0;
    localparam t_span SPAN_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_M_XX = 3'd0,
        CFG_M_XY = 3'd1,
        CFG_M_TX = 3'd2,
        CFG_M_YX = 3'd3,
        CFG_M_YY = 3'd4,
        CFG_M_TY = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_q rect_x;
        t_q rect_y;
        t_q rect_w;
        t_q rect_h;
    } t_in_word;

    typedef struct packed {
        t_q    box_left;
        t_q    box_top;
        t_span box_width;
        t_span box_height;
    } t_out_word;

    typedef struct packed {
        t_q x0;
        t_q x1;
        t_q y0;
        t_q y1;
    } t_corners;

    // saturate a wide signed value to Q16.16 range
    function automatic t_q sat_q(input t_wide v);
        logic [WIDE_WIDTH-Q_WIDTH:0] top;
        top = v[WIDE_WIDTH-1:Q_WIDTH-1];
        if (top == '0 || top == '1) begin
            return v[Q_WIDTH-1:0];
        end else if (v[WIDE_WIDTH-1]) begin
            return Q_MIN;
        end else begin
            return Q_MAX;
        end
    endfunction

    // Q32.32 product back to Q16.16, rounded toward zero, saturated
    function automatic t_q q_trunc(input t_prod p);
        t_wide q;
        q = t_wide'(p >>> Q_FRAC_BITS);
        if (p[PROD_WIDTH-1] && (p[Q_FRAC_BITS-1:0] != '0)) begin
            q = q + t_wide'(1);
        end
        return sat_q(q);
    endfunction

endpackage

### sv/affine_rect_bounding_box_top.sv
`timescale 1ns / 1ps

// Bounding box of an affinely mapped rectangle. Pulse i_start with a
// rectangle word (x, y, w, h, signed Q16.16) on i_rect; after the corner,
// map and bbox stages o_valid is high for exactly one cycle with the box
// word on o_box (left, top, width, height). One word is taken every cycle:
// o_busy is always low and any number of words may be in flight. The
// datapath runs through corner sums, the 32x32 multipliers, truncation,
// two saturating adds, and a two-level min/max ahead of the span stage.
// The receiver cannot stall; o_valid is a strobe and must be taken when it
// shows. Matrix registers (m_xx, m_xy, m_tx, m_yx, m_yy, m_ty by index 0..5)
// are written through the cfg channel, which is always ready; write them
// only while no word is in flight. Indexes above five are dropped.
module affine_rect_bounding_box_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command side
    input  logic                                i_start,
    output logic                                o_busy,
    input  arbb_pkg::t_in_word                  i_rect,
    // result side
    output logic                                o_valid,
    output arbb_pkg::t_out_word                 o_box,
    // matrix register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arbb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  arbb_pkg::t_q                        i_cfg_data
);

    // matrix registers, Q16.16
    arbb_pkg::t_q r_m_xx, r_m_xy, r_m_tx, r_m_yx, r_m_yy, r_m_ty;

    logic               in_take;
    logic               v_corner, v_map_x, v_map_y;
    arbb_pkg::t_corners corners;
    arbb_pkg::t_q       px [4];
    arbb_pkg::t_q       py [4];

    // fully pipelined, nothing ever backs up
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_xx <= arbb_pkg::Q_ONE;
            r_m_xy <= arbb_pkg::Q_ZERO;
            r_m_tx <= arbb_pkg::Q_ZERO;
            r_m_yx <= arbb_pkg::Q_ZERO;
            r_m_yy <= arbb_pkg::Q_ONE;
            r_m_ty <= arbb_pkg::Q_ZERO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                arbb_pkg::CFG_M_XX: r_m_xx <= i_cfg_data;
                arbb_pkg::CFG_M_XY: r_m_xy <= i_cfg_data;
                arbb_pkg::CFG_M_TX: r_m_tx <= i_cfg_data;
                arbb_pkg::CFG_M_YX: r_m_yx <= i_cfg_data;
                arbb_pkg::CFG_M_YY: r_m_yy <= i_cfg_data;
                arbb_pkg::CFG_M_TY: r_m_ty <= i_cfg_data;
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // stage 1: far corner
    arbb_corner u_corner (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_take),
        .i_rect    (i_rect),
        .o_valid   (v_corner),
        .o_corners (corners)
    );

    // stages 2-5: X' and Y' lanes side by side
    arbb_map u_map_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (v_corner),
        .i_corners (corners),
        .i_ca      (r_m_xx),
        .i_cb      (r_m_xy),
        .i_t       (r_m_tx),
        .o_valid   (v_map_x),
        .o_val     (px)
    );

    arbb_map u_map_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (v_corner),
        .i_corners (corners),
        .i_ca      (r_m_yx),
        .i_cb      (r_m_yy),
        .i_t       (r_m_ty),
        .o_valid   (v_map_y),
        .o_val     (py)
    );

    // stages 6-8: min/max and spans; both lanes run in lockstep
    arbb_bbox u_bbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_map_x && v_map_y),
        .i_px    (px),
        .i_py    (py),
        .o_valid (o_valid),
        .o_box   (o_box)
    );

endmodule

### sv/arbb_corner.sv
`timescale 1ns / 1ps

// Stage 1: far corner coordinates x + w, y + h, saturated.
module arbb_corner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  arbb_pkg::t_in_word i_rect,
    output logic               o_valid,
    output arbb_pkg::t_corners o_corners
);

    logic               r_valid;
    arbb_pkg::t_corners r_corners;
    arbb_pkg::t_corners n_corners;

    always_comb begin
        n_corners.x0 = i_rect.rect_x;
        n_corners.y0 = i_rect.rect_y;
        n_corners.x1 = arbb_pkg::sat_q(arbb_pkg::t_wide'(i_rect.rect_x)
                                       + arbb_pkg::t_wide'(i_rect.rect_w));
        n_corners.y1 = arbb_pkg::sat_q(arbb_pkg::t_wide'(i_rect.rect_y)
                                       + arbb_pkg::t_wide'(i_rect.rect_h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_corners <= n_corners;
    end

    assign o_valid   = r_valid;
    assign o_corners = r_corners;

endmodule

### sv/arbb_map.sv
`timescale 1ns / 1ps

// One output axis of the affine map for all four corners.
// Corner order: (x0,y0) (x0,y1) (x1,y0) (x1,y1).
// Stages: multiply, truncate, cross sum, translate.
module arbb_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  arbb_pkg::t_corners i_corners,
    input  arbb_pkg::t_q       i_ca,
    input  arbb_pkg::t_q       i_cb,
    input  arbb_pkg::t_q       i_t,
    output logic               o_valid,
    output arbb_pkg::t_q       o_val [4]
);

    logic r_v_mul, r_v_trn, r_v_sum, r_v_out;

    // only four distinct products across the four corners
    arbb_pkg::t_prod r_p_ax0, r_p_ax1, r_p_by0, r_p_by1;
    arbb_pkg::t_q    r_q_ax0, r_q_ax1, r_q_by0, r_q_by1;
    arbb_pkg::t_q    n_sum [4];
    arbb_pkg::t_q    r_sum [4];
    arbb_pkg::t_q    r_out [4];

    always_comb begin
        n_sum[0] = arbb_pkg::sat_q(arbb_pkg::t_wide'(r_q_ax0) + arbb_pkg::t_wide'(r_q_by0));
        n_sum[1] = arbb_pkg::sat_q(arbb_pkg::t_wide'(r_q_ax0) + arbb_pkg::t_wide'(r_q_by1));
        n_sum[2] = arbb_pkg::sat_q(arbb_pkg::t_wide'(r_q_ax1) + arbb_pkg::t_wide'(r_q_by0));
        n_sum[3] = arbb_pkg::sat_q(arbb_pkg::t_wide'(r_q_ax1) + arbb_pkg::t_wide'(r_q_by1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mul <= 1'b0;
            r_v_trn <= 1'b0;
            r_v_sum <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            r_v_mul <= i_valid;
            r_v_trn <= r_v_mul;
            r_v_sum <= r_v_trn;
            r_v_out <= r_v_sum;
        end
        r_p_ax0 <= arbb_pkg::t_prod'(i_ca) * arbb_pkg::t_prod'(i_corners.x0);
        r_p_ax1 <= arbb_pkg::t_prod'(i_ca) * arbb_pkg::t_prod'(i_corners.x1);
        r_p_by0 <= arbb_pkg::t_prod'(i_cb) * arbb_pkg::t_prod'(i_corners.y0);
        r_p_by1 <= arbb_pkg::t_prod'(i_cb) * arbb_pkg::t_prod'(i_corners.y1);
        r_q_ax0 <= arbb_pkg::q_trunc(r_p_ax0);
        r_q_ax1 <= arbb_pkg::q_trunc(r_p_ax1);
        r_q_by0 <= arbb_pkg::q_trunc(r_p_by0);
        r_q_by1 <= arbb_pkg::q_trunc(r_p_by1);
        for (int i = 0; i < 4; i++) begin
            r_sum[i] <= n_sum[i];
            r_out[i] <= arbb_pkg::sat_q(arbb_pkg::t_wide'(r_sum[i]) + arbb_pkg::t_wide'(i_t));
        end
    end

    assign o_valid = r_v_out;
    assign o_val   = r_out;

endmodule

### sv/arbb_bbox.sv
`timescale 1ns / 1ps

// Min/max over the four mapped corners, then spans.
// Stages: pairwise min/max, final min/max, span and output word.
module arbb_bbox (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  arbb_pkg::t_q        i_px [4],
    input  arbb_pkg::t_q        i_py [4],
    output logic                o_valid,
    output arbb_pkg::t_out_word o_box
);

    logic r_v_pair, r_v_fin, r_v_out;

    // [0] covers corners 0,1 and [1] covers corners 2,3
    arbb_pkg::t_q r_lx [2];
    arbb_pkg::t_q r_hx [2];
    arbb_pkg::t_q r_ly [2];
    arbb_pkg::t_q r_hy [2];
    arbb_pkg::t_q r_lx_f, r_hx_f, r_ly_f, r_hy_f;
    arbb_pkg::t_out_word r_box;
    arbb_pkg::t_out_word n_box;

    function automatic arbb_pkg::t_span span_of(input arbb_pkg::t_q hi,
                                                input arbb_pkg::t_q lo);
        arbb_pkg::t_wide d;
        d = arbb_pkg::t_wide'(hi) - arbb_pkg::t_wide'(lo);
        // hi >= lo, so d is never negative
        if (d > arbb_pkg::t_wide'(arbb_pkg::SPAN_MAX)) begin
            return arbb_pkg::SPAN_MAX;
        end
        return d[arbb_pkg::SPAN_WIDTH-1:0];
    endfunction

    always_comb begin
        n_box.box_left   = r_lx_f;
        n_box.box_top    = r_ly_f;
        n_box.box_width  = span_of(r_hx_f, r_lx_f);
        n_box.box_height = span_of(r_hy_f, r_ly_f);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_pair <= 1'b0;
            r_v_fin  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            r_v_pair <= i_valid;
            r_v_fin  <= r_v_pair;
            r_v_out  <= r_v_fin;
        end
        for (int k = 0; k < 2; k++) begin
            r_lx[k] <= (i_px[2*k] < i_px[2*k+1]) ? i_px[2*k] : i_px[2*k+1];
            r_hx[k] <= (i_px[2*k] > i_px[2*k+1]) ? i_px[2*k] : i_px[2*k+1];
            r_ly[k] <= (i_py[2*k] < i_py[2*k+1]) ? i_py[2*k] : i_py[2*k+1];
            r_hy[k] <= (i_py[2*k] > i_py[2*k+1]) ? i_py[2*k] : i_py[2*k+1];
        end
        r_lx_f <= (r_lx[0] < r_lx[1]) ? r_lx[0] : r_lx[1];
        r_hx_f <= (r_hx[0] > r_hx[1]) ? r_hx[0] : r_hx[1];
        r_ly_f <= (r_ly[0] < r_ly[1]) ? r_ly[0] : r_ly[1];
        r_hy_f <= (r_hy[0] > r_hy[1]) ? r_hy[0] : r_hy[1];
        r_box  <= n_box;
    end

    assign o_valid = r_v_out;
    assign o_box   = r_box;

endmodule
